FILE: src/tcw_pkg.sv
// Shared types and constants for the text console cell writer.
`default_nettype none

package tcw_pkg;

  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 4;
  localparam int INDEX_W = 11;
  localparam int MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic CFG_FG = 1'b0;
  localparam logic CFG_BG = 1'b1;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0020;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUTC    = 3'd0,
    OP_NEWLINE = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_READ    = 3'd3,
    OP_NOP     = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
    logic               in_range;
    logic [ATTR_W-1:0]  attr;
  } op_t;

endpackage

`default_nettype wire

FILE: src/text_console_cell_writer.sv
// Top level of the text console cell writer.
// Commands arrive as beats on the in_ channel: mode 0 writes in_char_code at the
// caret (code 10 is a newline), mode 1 clears the screen in the current colors,
// mode 2 returns the cell at in_cell_index. Every command gives one beat on the
// out_ channel with the read data, the caret after the command and a scroll flag.
// Colors are written through the cfg_ channel (index 0 foreground, 1 background),
// which is always ready; write them only while no command is in flight.
// A character write, newline or read passes through the engine's EXEC and RESP
// states; its result is registered in the output register. A scroll walks the
// cell memory through its single write port, copying each row up by one and
// blanking the last row; a write that found the caret past the last cell is carried
// out afterwards. A clear writes a space in the current colors to every cell. A
// two-entry command queue lets the input side keep taking beats while the engine
// works or while a result waits in the output register. When the receiver stalls,
// the result holds and the engine stops with its next result; once the queue fills, in_ready drops.
// After reset the engine zeroes the whole cell memory, one cell per cycle; in_ready
// stays low during that pass.
`default_nettype none

module text_console_cell_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tcw_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  wire logic [tcw_pkg::INDEX_W-1:0]   in_cell_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tcw_pkg::CELL_W-1:0]         out_read_data,
  output logic [tcw_pkg::INDEX_W-1:0]        out_caret,
  output logic                               out_scrolled,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [tcw_pkg::COLOR_W-1:0]   cfg_data
);

  logic         init_busy;
  logic         q_can_push;
  logic         q_push;
  tcw_pkg::op_t q_push_op;
  logic         q_valid;
  logic         q_pop;
  tcw_pkg::op_t q_op;

  tcw_front #(
    .CELLS (ROWS * COLUMNS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .init_busy     (init_busy),
    .q_ready       (q_can_push),
    .q_push        (q_push),
    .q_op          (q_push_op)
  );

  tcw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (q_push_op),
    .can_push  (q_can_push),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_op    (q_op)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_op          (q_op),
    .q_pop         (q_pop),
    .init_busy     (init_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_caret     (out_caret),
    .out_scrolled  (out_scrolled)
  );

endmodule

`default_nettype wire

FILE: src/tcw_front.sv
// Front end: input acceptance, command classification and color registers.
`default_nettype none

module tcw_front #(
  parameter int CELLS = 2000
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tcw_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  wire logic [tcw_pkg::INDEX_W-1:0]   in_cell_index,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [tcw_pkg::COLOR_W-1:0]   cfg_data,
  input  wire logic                          init_busy,
  input  wire logic                          q_ready,
  output logic                               q_push,
  output tcw_pkg::op_t                       q_op
);

  logic [tcw_pkg::COLOR_W-1:0] fg_r, fg_nxt;
  logic [tcw_pkg::COLOR_W-1:0] bg_r, bg_nxt;
  tcw_pkg::op_kind_t           kind;

  assign cfg_ready = 1'b1;
  assign in_ready  = q_ready && !init_busy;
  assign q_push    = in_valid && in_ready;

  always_comb begin
    fg_nxt = fg_r;
    bg_nxt = bg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        tcw_pkg::CFG_FG: fg_nxt = cfg_data;
        tcw_pkg::CFG_BG: bg_nxt = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= tcw_pkg::FG_RESET;
      bg_r <= tcw_pkg::BG_RESET;
    end else begin
      fg_r <= fg_nxt;
      bg_r <= bg_nxt;
    end
  end

  always_comb begin
    unique case (in_mode)
      tcw_pkg::MODE_WRITE: begin
        kind = (in_char_code == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::OP_NEWLINE
                                                       : tcw_pkg::OP_PUTC;
      end
      tcw_pkg::MODE_CLEAR: kind = tcw_pkg::OP_CLEAR;
      tcw_pkg::MODE_READ:  kind = tcw_pkg::OP_READ;
      default:             kind = tcw_pkg::OP_NOP;
    endcase
  end

  assign q_op.kind       = kind;
  assign q_op.char_code  = in_char_code;
  assign q_op.cell_index = in_cell_index;
  assign q_op.in_range   = (32'(in_cell_index) < 32'(CELLS));
  assign q_op.attr       = {bg_r, fg_r};

endmodule

`default_nettype wire

FILE: src/tcw_queue.sv
// Short command queue between the front end and the execution engine.
`default_nettype none

module tcw_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tcw_pkg::op_t  push_op,
  output logic               can_push,
  output logic               pop_valid,
  input  wire logic          pop,
  output tcw_pkg::op_t       pop_op
);

  tcw_pkg::op_t                  slot_r [tcw_pkg::Q_DEPTH];
  logic [tcw_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [tcw_pkg::Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [tcw_pkg::Q_CNT_W-1:0]   count_r, count_nxt;
  logic                          do_pop;

  assign can_push  = (count_r != tcw_pkg::Q_CNT_W'(tcw_pkg::Q_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_op    = slot_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tcw_pkg::Q_PTR_W'(tcw_pkg::Q_DEPTH - 1)) ? '0
                                                                          : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == tcw_pkg::Q_PTR_W'(tcw_pkg::Q_DEPTH - 1)) ? '0
                                                                          : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tcw_pkg::Q_CNT_W'(tcw_pkg::Q_DEPTH))
    else $error("Queue count exceeds its depth.");

  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_push)
    else $error("Queue written while full.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("Queue pointers disagree while empty.");

endmodule

`default_nettype wire

FILE: src/tcw_back.sv
// Execution engine: cell store, caret, scroll and clear sweeps, result register.
`default_nettype none

module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire tcw_pkg::op_t                  q_op,
  output logic                               q_pop,
  output logic                               init_busy,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tcw_pkg::CELL_W-1:0]         out_read_data,
  output logic [tcw_pkg::INDEX_W-1:0]        out_caret,
  output logic                               out_scrolled
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int MOVE  = CELLS - COLUMNS;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int AW    = $clog2(CELLS);
  localparam int COLW  = $clog2(COLUMNS);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXEC   = 6'b000010,
    ST_MOVE   = 6'b000100,
    ST_FILL   = 6'b001000,
    ST_CLEAR  = 6'b010000,
    ST_RESP   = 6'b100000
  } state_t;

  state_t                       state_r, state_nxt;
  tcw_pkg::op_t                 op_r, op_nxt;
  logic [CW-1:0]                caret_r, caret_nxt;
  logic [CW-1:0]                row_base_r, row_base_nxt;
  logic [COLW-1:0]              col_r, col_nxt;
  logic [CW-1:0]                ptr_r, ptr_nxt;
  logic                         scrolled_r, scrolled_nxt;
  logic                         rd_flag_r, rd_flag_nxt;
  logic                         ret_exec_r, ret_exec_nxt;
  logic                         init_busy_r, init_busy_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_load;
  logic [tcw_pkg::CELL_W-1:0]   out_data_r;
  logic [tcw_pkg::INDEX_W-1:0]  out_caret_r;
  logic                         out_scrolled_r;

  logic [tcw_pkg::CELL_W-1:0]   mem [CELLS];
  logic [tcw_pkg::CELL_W-1:0]   mem_rdata_r;
  logic                         we;
  logic [AW-1:0]                waddr;
  logic [tcw_pkg::CELL_W-1:0]   wdata;
  logic                         re;
  logic [AW-1:0]                raddr;
  logic [CW-1:0]                next_row;
  logic                         is_char;

  assign init_busy     = init_busy_r;
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_caret     = out_caret_r;
  assign out_scrolled  = out_scrolled_r;

  assign next_row = row_base_r + CW'(COLUMNS);
  assign is_char  = (op_r.kind == tcw_pkg::OP_PUTC) || (op_r.kind == tcw_pkg::OP_NEWLINE);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    caret_nxt     = caret_r;
    row_base_nxt  = row_base_r;
    col_nxt       = col_r;
    ptr_nxt       = ptr_r;
    scrolled_nxt  = scrolled_r;
    rd_flag_nxt   = rd_flag_r;
    ret_exec_nxt  = ret_exec_r;
    init_busy_nxt = init_busy_r;
    q_pop         = 1'b0;
    out_load      = 1'b0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    re            = 1'b0;
    raddr         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          op_nxt       = q_op;
          scrolled_nxt = 1'b0;
          rd_flag_nxt  = 1'b0;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (is_char && (caret_r == CW'(CELLS))) begin
          ptr_nxt      = '0;
          caret_nxt    = CW'(MOVE);
          row_base_nxt = CW'(MOVE);
          col_nxt      = '0;
          scrolled_nxt = 1'b1;
          ret_exec_nxt = 1'b1;
          state_nxt    = ST_MOVE;
        end else begin
          unique case (op_r.kind)
            tcw_pkg::OP_PUTC: begin
              we        = 1'b1;
              waddr     = caret_r[AW-1:0];
              wdata     = {op_r.attr, op_r.char_code};
              caret_nxt = caret_r + 1'b1;
              if (col_r == COLW'(COLUMNS - 1)) begin
                col_nxt      = '0;
                row_base_nxt = next_row;
              end else begin
                col_nxt = col_r + 1'b1;
              end
              state_nxt = ST_RESP;
            end
            tcw_pkg::OP_NEWLINE: begin
              col_nxt = '0;
              if (row_base_r == CW'(MOVE)) begin
                ptr_nxt      = '0;
                caret_nxt    = CW'(MOVE);
                scrolled_nxt = 1'b1;
                ret_exec_nxt = 1'b0;
                state_nxt    = ST_MOVE;
              end else begin
                row_base_nxt = next_row;
                caret_nxt    = next_row;
                state_nxt    = ST_RESP;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              ptr_nxt      = '0;
              caret_nxt    = '0;
              row_base_nxt = '0;
              col_nxt      = '0;
              state_nxt    = ST_CLEAR;
            end
            tcw_pkg::OP_READ: begin
              if (op_r.in_range) begin
                re          = 1'b1;
                raddr       = AW'(op_r.cell_index);
                rd_flag_nxt = 1'b1;
              end
              state_nxt = ST_RESP;
            end
            tcw_pkg::OP_NOP: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_MOVE: begin
        if (ptr_r != CW'(MOVE)) begin
          re    = 1'b1;
          raddr = AW'(ptr_r + CW'(COLUMNS));
        end
        if (ptr_r != '0) begin
          we    = 1'b1;
          waddr = AW'(ptr_r - 1'b1);
          wdata = mem_rdata_r;
        end
        if (ptr_r == CW'(MOVE)) begin
          state_nxt = ST_FILL;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = ptr_r[AW-1:0];
        wdata = tcw_pkg::BLANK_CELL;
        if (ptr_r == CW'(CELLS - 1)) begin
          state_nxt = ret_exec_r ? ST_EXEC : ST_RESP;
          ret_exec_nxt = 1'b0;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = ptr_r[AW-1:0];
        wdata = init_busy_r ? '0 : {op_r.attr, tcw_pkg::SPACE_CODE};
        if (ptr_r == CW'(CELLS - 1)) begin
          if (init_busy_r) begin
            init_busy_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_RESP;
          end
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (q_valid) begin
            q_pop        = 1'b1;
            op_nxt       = q_op;
            scrolled_nxt = 1'b0;
            rd_flag_nxt  = 1'b0;
            state_nxt    = ST_EXEC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      caret_r     <= '0;
      row_base_r  <= '0;
      col_r       <= '0;
      ptr_r       <= '0;
      scrolled_r  <= 1'b0;
      rd_flag_r   <= 1'b0;
      ret_exec_r  <= 1'b0;
      init_busy_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      caret_r     <= caret_nxt;
      row_base_r  <= row_base_nxt;
      col_r       <= col_nxt;
      ptr_r       <= ptr_nxt;
      scrolled_r  <= scrolled_nxt;
      rd_flag_r   <= rd_flag_nxt;
      ret_exec_r  <= ret_exec_nxt;
      init_busy_r <= init_busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    if (out_load) begin
      out_data_r     <= rd_flag_r ? mem_rdata_r : '0;
      out_caret_r    <= tcw_pkg::INDEX_W'(caret_r);
      out_scrolled_r <= scrolled_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      mem_rdata_r <= mem[raddr];
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    caret_r <= CW'(CELLS))
    else $error("Caret beyond the end of the screen.");

  assert property (@(posedge clk) disable iff (!rst_n)
    caret_r == row_base_r + CW'(col_r))
    else $error("Caret does not match its row and column.");

  assert property (@(posedge clk) disable iff (!rst_n)
    init_busy_r |-> (state_r == ST_CLEAR))
    else $error("Engine left the reset clearing pass early.");

  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !init_busy_r)
    else $error("Command taken during the reset clearing pass.");

endmodule

`default_nettype wire

FILE: bench/text_console_cell_writer_test.sv
// Self-checking testbench for the text console cell writer with a screen predictor.
module text_console_cell_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MAX_REPORTS = 10;
  localparam int ITEMS_PER_PHASE = 320;
  localparam int SETTLE_CYCLES = 2 * CELL_COUNT + 16;
  localparam logic [tcw_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic [tcw_pkg::COLOR_W-1:0] PHASE_FG [4] = '{4'h0, 4'hF, 4'h6, 4'hA};
  localparam logic [tcw_pkg::COLOR_W-1:0] PHASE_BG [4] = '{4'h0, 4'hF, 4'h9, 4'h5};
  localparam int SEND_IDLE [4] = '{0, 50, 0, 24};
  localparam int RECV_STALL [4] = '{0, 0, 50, 24};

  typedef struct packed {
    logic [tcw_pkg::MODE_W-1:0]  mode;
    logic [tcw_pkg::CHAR_W-1:0]  char_code;
    logic [tcw_pkg::INDEX_W-1:0] cell_index;
  } console_cmd_t;

  typedef struct packed {
    logic [tcw_pkg::CELL_W-1:0]  read_data;
    logic [tcw_pkg::INDEX_W-1:0] caret;
    logic                        scrolled;
  } console_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [tcw_pkg::MODE_W-1:0] in_mode = '0;
  logic [tcw_pkg::CHAR_W-1:0] in_char_code = '0;
  logic [tcw_pkg::INDEX_W-1:0] in_cell_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [tcw_pkg::CELL_W-1:0] out_read_data;
  logic [tcw_pkg::INDEX_W-1:0] out_caret;
  logic out_scrolled;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = tcw_pkg::CFG_FG;
  logic [tcw_pkg::COLOR_W-1:0] cfg_data = '0;

  logic [tcw_pkg::CELL_W-1:0] screen_model [CELL_COUNT];
  int caret_model;
  logic [tcw_pkg::COLOR_W-1:0] fg_model;
  logic [tcw_pkg::COLOR_W-1:0] bg_model;

  console_cmd_t pending_cmds [$];
  console_result_t due_results [$];
  int queued_count = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  text_console_cell_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_char_code(in_char_code),
    .in_cell_index(in_cell_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_read_data(out_read_data),
    .out_caret(out_caret),
    .out_scrolled(out_scrolled),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("text_console_cell_writer_test: FAIL");
    $finish;
  end

  task automatic scroll_screen();
    for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
      screen_model[i] = screen_model[i + COLUMNS];
    end
    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
      screen_model[i] = tcw_pkg::BLANK_CELL;
    end
  endtask

  task automatic execute_command(input console_cmd_t cmd, output console_result_t res);
    res = '0;
    case (cmd.mode)
      tcw_pkg::MODE_WRITE: begin
        if (caret_model >= CELL_COUNT) begin
          scroll_screen();
          caret_model = CELL_COUNT - COLUMNS;
          res.scrolled = 1'b1;
        end
        if (cmd.char_code == tcw_pkg::NEWLINE_CODE) begin
          caret_model = (caret_model / COLUMNS + 1) * COLUMNS;
          if (caret_model >= CELL_COUNT) begin
            scroll_screen();
            caret_model -= COLUMNS;
            res.scrolled = 1'b1;
          end
        end else begin
          screen_model[caret_model] = {bg_model, fg_model, cmd.char_code};
          caret_model++;
        end
      end
      tcw_pkg::MODE_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) begin
          screen_model[i] = {bg_model, fg_model, tcw_pkg::SPACE_CODE};
        end
        caret_model = 0;
      end
      tcw_pkg::MODE_READ: begin
        if (cmd.cell_index < CELL_COUNT) begin
          res.read_data = screen_model[cmd.cell_index];
        end
      end
      default: begin
      end
    endcase
    res.caret = caret_model[tcw_pkg::INDEX_W-1:0];
  endtask

  task automatic report_mismatch(input string what, input console_result_t want,
                                 input console_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: expected data=%h caret=%0d scrolled=%0b,",
               $time, what, want.read_data, want.caret, want.scrolled,
               " got data=%h caret=%0d scrolled=%0b",
               got.read_data, got.caret, got.scrolled);
    end
  endtask

  always @(posedge clk) begin : drive_commands
    console_cmd_t next_cmd;
    console_result_t predicted;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        execute_command(console_cmd_t'({in_mode, in_char_code, in_cell_index}), predicted);
        due_results.push_back(predicted);
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_mode <= next_cmd.mode;
          in_char_code <= next_cmd.char_code;
          in_cell_index <= next_cmd.cell_index;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    console_result_t want;
    console_result_t got;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_read_data, out_caret, out_scrolled};
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result beat", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got.read_data !== want.read_data || got.caret !== want.caret ||
              got.scrolled !== want.scrolled) begin
            report_mismatch("result mismatch", want, got);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_cmd(input logic [tcw_pkg::MODE_W-1:0] mode,
                          input logic [tcw_pkg::CHAR_W-1:0] ch,
                          input logic [tcw_pkg::INDEX_W-1:0] idx);
    pending_cmds.push_back('{mode, ch, idx});
    if (mode != MODE_UNUSED) begin
      queued_count++;
    end
  endtask

  function automatic logic [tcw_pkg::INDEX_W-1:0] read_index();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      return tcw_pkg::INDEX_W'($urandom_range(CELL_COUNT - 1));
    end else if (pick < 60) begin
      return tcw_pkg::INDEX_W'($urandom_range(COLUMNS - 1));
    end else if (pick < 85) begin
      return tcw_pkg::INDEX_W'($urandom_range(CELL_COUNT - 1, CELL_COUNT - COLUMNS));
    end else begin
      return tcw_pkg::INDEX_W'($urandom_range(2 ** tcw_pkg::INDEX_W - 1, CELL_COUNT));
    end
  endfunction

  // Walks the caret onto the last row, fills it, and then either breaks the line or writes
  // one more character, so that both ways of running past the last cell are exercised.
  task automatic queue_bottom_run(input bit end_with_newline);
    repeat (ROWS - 1) begin
      push_cmd(tcw_pkg::MODE_WRITE, tcw_pkg::NEWLINE_CODE,
               tcw_pkg::INDEX_W'($urandom_range(2047)));
    end
    repeat (COLUMNS) begin
      push_cmd(tcw_pkg::MODE_WRITE, tcw_pkg::CHAR_W'($urandom_range(126, 32)), '0);
    end
    if (end_with_newline) begin
      push_cmd(tcw_pkg::MODE_WRITE, tcw_pkg::NEWLINE_CODE, '0);
    end else begin
      push_cmd(tcw_pkg::MODE_WRITE, tcw_pkg::CHAR_W'($urandom_range(126, 32)), '0);
    end
    push_cmd(tcw_pkg::MODE_READ, '0,
             tcw_pkg::INDEX_W'($urandom_range(CELL_COUNT - 1, CELL_COUNT - COLUMNS)));
    push_cmd(tcw_pkg::MODE_READ, '0,
             tcw_pkg::INDEX_W'($urandom_range(CELL_COUNT - COLUMNS - 1,
                                              CELL_COUNT - 2 * COLUMNS)));
  endtask

  task automatic queue_random_commands(input int count);
    int start_count;
    int pick;
    start_count = queued_count;
    while (queued_count - start_count < count) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        repeat ($urandom_range(40, 1)) begin
          push_cmd(tcw_pkg::MODE_WRITE,
                   ($urandom_range(99) < 6) ? tcw_pkg::NEWLINE_CODE
                                            : tcw_pkg::CHAR_W'($urandom_range(255)),
                   tcw_pkg::INDEX_W'($urandom_range(2047)));
        end
      end else if (pick < 72) begin
        repeat ($urandom_range(6, 1)) begin
          push_cmd(tcw_pkg::MODE_READ, tcw_pkg::CHAR_W'($urandom_range(255)), read_index());
        end
      end else if (pick < 84) begin
        repeat ($urandom_range(8, 1)) begin
          push_cmd(tcw_pkg::MODE_WRITE, tcw_pkg::NEWLINE_CODE, '0);
        end
      end else if (pick < 91) begin
        repeat ($urandom_range(3, 1)) begin
          push_cmd(MODE_UNUSED, tcw_pkg::CHAR_W'($urandom_range(255)),
                   tcw_pkg::INDEX_W'($urandom_range(2047)));
        end
      end else if (pick < 94) begin
        queue_bottom_run(1'($urandom_range(1)));
      end else if (pick < 96) begin
        push_cmd(tcw_pkg::MODE_CLEAR, tcw_pkg::CHAR_W'($urandom_range(255)),
                 tcw_pkg::INDEX_W'($urandom_range(2047)));
        push_cmd(tcw_pkg::MODE_READ, '0, read_index());
      end else begin
        push_cmd(tcw_pkg::MODE_W'($urandom_range(3)), tcw_pkg::CHAR_W'($urandom_range(255)),
                 tcw_pkg::INDEX_W'($urandom_range(2047)));
      end
    end
  endtask

  task automatic queue_directed_commands();
    push_cmd(tcw_pkg::MODE_READ, '0, '0);
    push_cmd(tcw_pkg::MODE_WRITE, 8'h00, '0);
    push_cmd(tcw_pkg::MODE_WRITE, 8'hFF, '1);
    push_cmd(tcw_pkg::MODE_WRITE, 8'h41, '0);
    push_cmd(tcw_pkg::MODE_READ, '0, tcw_pkg::INDEX_W'(0));
    push_cmd(tcw_pkg::MODE_READ, '0, tcw_pkg::INDEX_W'(1));
    push_cmd(tcw_pkg::MODE_READ, '0, tcw_pkg::INDEX_W'(2));
    push_cmd(tcw_pkg::MODE_WRITE, tcw_pkg::NEWLINE_CODE, '0);
    push_cmd(tcw_pkg::MODE_WRITE, 8'h42, '0);
    push_cmd(tcw_pkg::MODE_READ, '0, tcw_pkg::INDEX_W'(COLUMNS));
    push_cmd(tcw_pkg::MODE_READ, '0, tcw_pkg::INDEX_W'(CELL_COUNT - 1));
    push_cmd(tcw_pkg::MODE_READ, '0, tcw_pkg::INDEX_W'(CELL_COUNT));
    push_cmd(tcw_pkg::MODE_READ, 8'hFF, '1);
    push_cmd(MODE_UNUSED, 8'hFF, '1);
    push_cmd(tcw_pkg::MODE_CLEAR, 8'hFF, '1);
    push_cmd(tcw_pkg::MODE_READ, '0, tcw_pkg::INDEX_W'(0));
    push_cmd(tcw_pkg::MODE_READ, '0, tcw_pkg::INDEX_W'(CELL_COUNT - 1));
    push_cmd(tcw_pkg::MODE_WRITE, tcw_pkg::NEWLINE_CODE, '0);
    push_cmd(tcw_pkg::MODE_WRITE, tcw_pkg::SPACE_CODE, '0);
    push_cmd(tcw_pkg::MODE_READ, '0, tcw_pkg::INDEX_W'(COLUMNS));
  endtask

  task automatic wait_until_drained();
    do @(negedge clk); while (pending_cmds.size() != 0 || in_valid || due_results.size() != 0);
  endtask

  task automatic write_color(input logic which, input logic [tcw_pkg::COLOR_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (which == tcw_pkg::CFG_FG) begin
      fg_model = value;
    end else begin
      bg_model = value;
    end
  endtask

  initial begin : run_test
    for (int i = 0; i < CELL_COUNT; i++) begin
      screen_model[i] = '0;
    end
    caret_model = 0;
    fg_model = tcw_pkg::FG_RESET;
    bg_model = tcw_pkg::BG_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    queue_directed_commands();
    wait_until_drained();
    for (int phase = 0; phase < 4; phase++) begin
      write_color(tcw_pkg::CFG_FG, PHASE_FG[phase]);
      write_color(tcw_pkg::CFG_BG, PHASE_BG[phase]);
      send_idle_pct = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];
      if (phase == 0) begin
        queue_bottom_run(1'b1);
        queue_bottom_run(1'b0);
      end
      queue_random_commands(ITEMS_PER_PHASE / 2);
      // The sender holds off here until every beat in flight has come back.
      wait_until_drained();
      queue_random_commands(ITEMS_PER_PHASE / 2);
      wait_until_drained();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("text_console_cell_writer_test: PASS");
    end else begin
      $display("text_console_cell_writer_test: FAIL");
    end
    $finish;
  end

endmodule
